@@ rtl/core/ipm_pkg.sv @@
// Shared types, widths and constants of the inverse perspective mapping unit.
// Used by the CORDIC cell and the top level; depends on nothing.
package ipm_pkg;

	// CORDIC datapath width and angle width (Q.16 radians, signed).
	localparam int W  = 46;
	localparam int AW = 20;
	// Width of a scale times angle product.
	localparam int PW = 45;

	localparam int IMG_ROWS_DEF     = 480;
	localparam int IMG_COLS_DEF     = 640;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic signed [23:0] NEAR_LIMIT  = 24'sd25;
	localparam logic [16:0]        GAIN_Q16    = 17'd107922;
	localparam logic signed [AW-1:0] HALF_PI_Q16 = 20'sd102944;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NEAR  = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	localparam logic [2:0] REG_CAM_X    = 3'd0;
	localparam logic [2:0] REG_CAM_Y    = 3'd1;
	localparam logic [2:0] REG_CAM_H    = 3'd2;
	localparam logic [2:0] REG_ROW_SC   = 3'd3;
	localparam logic [2:0] REG_COL_SC   = 3'd4;
	localparam logic [2:0] REG_ROW_OFF  = 3'd5;
	localparam logic [2:0] REG_COL_OFF  = 3'd6;

	// Side information that travels with a word down the cell chain.
	typedef struct packed {
		logic [1:0]           st;
		logic signed [AW-1:0] psi;
	} side_t;

	// atan(2^-i) in Q.16, rounded to nearest.
	function automatic logic signed [AW-1:0] atan_q16(input int i);
		logic signed [AW-1:0] a;
		case (i)
			0:       a = 20'sd51472;
			1:       a = 20'sd30386;
			2:       a = 20'sd16055;
			3:       a = 20'sd8150;
			4:       a = 20'sd4091;
			5:       a = 20'sd2047;
			6:       a = 20'sd1024;
			7:       a = 20'sd512;
			8:       a = 20'sd256;
			9:       a = 20'sd128;
			10:      a = 20'sd64;
			11:      a = 20'sd32;
			12:      a = 20'sd16;
			13:      a = 20'sd8;
			14:      a = 20'sd4;
			15:      a = 20'sd2;
			16:      a = 20'sd1;
			default: a = 20'sd0;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/core/ipm_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with its pipeline register.
// Depends on ipm_pkg for widths, the arctangent table and the side struct.
module ipm_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic signed [ipm_pkg::W-1:0]  x_in,
	input  logic signed [ipm_pkg::W-1:0]  y_in,
	input  logic signed [ipm_pkg::AW-1:0] z_in,
	input  ipm_pkg::side_t                side_in,
	output logic                          vld_out,
	output logic signed [ipm_pkg::W-1:0]  x_out,
	output logic signed [ipm_pkg::W-1:0]  y_out,
	output logic signed [ipm_pkg::AW-1:0] z_out,
	output ipm_pkg::side_t                side_out
);
	import ipm_pkg::*;

	localparam logic signed [AW-1:0] ATAN = atan_q16(SHIFT);

	logic signed [W-1:0] xs, ys;
	logic vld_q;
	logic signed [W-1:0] x_q, y_q;
	logic signed [AW-1:0] z_q;
	side_t side_q;

	// Arithmetic shifts round toward minus infinity.
	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			if (!y_in[W-1]) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end
		end
	end

	assign vld_out  = vld_q;
	assign x_out    = x_q;
	assign y_out    = y_q;
	assign z_out    = z_q;
	assign side_out = side_q;

endmodule

@@ rtl/core/ipm_world_to_source_pixel_unit.sv @@
// Top level of the inverse perspective mapping unit: ground point to source pixel.
// Depends on ipm_pkg and ipm_cordic_cell.
//
// Usage: a ground point (world_x, world_y) word enters on the input channel
// (in_valid, in_stall) and one result word leaves on the output channel
// (out_valid, out_stall) carrying source_row, source_col, memory_row and status.
// A word is taken at a clock edge where valid is high and stall is low.
// The datapath is an input register, a chain of CORDIC_STEPS cells for the
// azimuth and ground range, a second chain of CORDIC_STEPS cells for the
// depression angle, a multiply stage and a rounding stage that also forms
// the output register. Unless the receiver stalls a waiting result, one word
// is accepted every cycle and the cell chain advances by one cell per clock.
// The whole pipeline advances together; when the receiver stalls while a
// result is waiting, every stage holds and in_stall is raised, so no word
// is lost. Reset clears all valid bits and loads the register defaults.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// next edge and must only be issued while the pipeline is empty.
module ipm_world_to_source_pixel_unit #(
	parameter int IMG_ROWS     = ipm_pkg::IMG_ROWS_DEF,
	parameter int IMG_COLS     = ipm_pkg::IMG_COLS_DEF,
	parameter int CORDIC_STEPS = ipm_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] world_x,
	input  logic signed [23:0] world_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        source_row,
	output logic [11:0]        source_col,
	output logic [11:0]        memory_row,
	output logic [1:0]         status
);
	import ipm_pkg::*;

	localparam int N = CORDIC_STEPS;
	localparam logic signed [AW-1:0] ROWS_S = AW'(IMG_ROWS);
	localparam logic signed [AW-1:0] COLS_S = AW'(IMG_COLS);
	localparam logic [11:0] ROW_MAX = 12'(IMG_ROWS - 1);

	// Configuration registers.
	logic signed [23:0] cam_x_q, cam_y_q;
	logic [22:0]        cam_h_q;
	logic [23:0]        row_sc_q, col_sc_q;
	logic signed [17:0] row_off_q, col_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q   <= 24'sd1024;
			cam_y_q   <= -24'sd2560;
			cam_h_q   <= 23'd1280;
			row_sc_q  <= 24'd936800;
			col_sc_q  <= 24'd1249700;
			row_off_q <= 18'sd15519;
			col_off_q <= 18'sd17157;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CAM_X:   cam_x_q   <= cfg_data;
				REG_CAM_Y:   cam_y_q   <= cfg_data;
				REG_CAM_H:   cam_h_q   <= cfg_data[22:0];
				REG_ROW_SC:  row_sc_q  <= cfg_data;
				REG_COL_SC:  col_sc_q  <= cfg_data;
				REG_ROW_OFF: row_off_q <= cfg_data[17:0];
				REG_COL_OFF: col_off_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// Every stage advances unless a finished result is held by the receiver.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Input stage: camera offset, special cases and half-plane pre-rotation.
	logic signed [24:0] x0, y0;
	logic signed [W-1:0] x0s, y0s;
	logic vld_s0;
	logic signed [W-1:0] cx_s0, cy_s0;
	logic signed [AW-1:0] psi_s0;
	side_t side_s0;

	assign x0  = {world_x[23], world_x} - {cam_x_q[23], cam_x_q};
	assign y0  = {world_y[23], world_y} - {cam_y_q[23], cam_y_q};
	assign x0s = W'(x0) <<< 16;
	assign y0s = W'(y0) <<< 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s0.psi <= '0;
			if (world_y <= NEAR_LIMIT) begin
				side_s0.st <= ST_NEAR;
			end else if (x0 == 25'sd0 && y0 == 25'sd0) begin
				side_s0.st <= ST_DEGEN;
			end else begin
				side_s0.st <= ST_OK;
			end
			if (!y0[24]) begin
				cx_s0  <= y0s;
				cy_s0  <= x0s;
				psi_s0 <= '0;
			end else if (!x0[24]) begin
				cx_s0  <= x0s;
				cy_s0  <= -y0s;
				psi_s0 <= HALF_PI_Q16;
			end else begin
				cx_s0  <= -x0s;
				cy_s0  <= y0s;
				psi_s0 <= -HALF_PI_Q16;
			end
		end
	end

	// Azimuth chain: z starts at the pre-rotation angle.
	logic                 av [0:N];
	logic signed [W-1:0]  ax [0:N];
	logic signed [W-1:0]  ay [0:N];
	logic signed [AW-1:0] az [0:N];
	side_t                as_ [0:N];

	assign av[0]  = vld_s0;
	assign ax[0]  = cx_s0;
	assign ay[0]  = cy_s0;
	assign az[0]  = psi_s0;
	assign as_[0] = side_s0;

	// Depression angle chain: the range meets the gain-scaled height.
	logic                 pv [0:N];
	logic signed [W-1:0]  px [0:N];
	logic signed [W-1:0]  py [0:N];
	logic signed [AW-1:0] pz [0:N];
	side_t                ps [0:N];
	logic [39:0]          h_gain;

	assign h_gain     = 40'(cam_h_q) * 40'(GAIN_Q16);
	assign pv[0]      = av[N];
	assign px[0]      = ax[N];
	assign py[0]      = W'(h_gain);
	assign pz[0]      = '0;
	assign ps[0].st   = as_[N].st;
	assign ps[0].psi  = az[N];

	for (genvar i = 0; i < N; i++) begin : g_cells
		ipm_cordic_cell #(.SHIFT(i)) u_az (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.vld_in(av[i]), .x_in(ax[i]), .y_in(ay[i]), .z_in(az[i]), .side_in(as_[i]),
			.vld_out(av[i+1]), .x_out(ax[i+1]), .y_out(ay[i+1]), .z_out(az[i+1]),
			.side_out(as_[i+1])
		);
		ipm_cordic_cell #(.SHIFT(i)) u_dep (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.vld_in(pv[i]), .x_in(px[i]), .y_in(py[i]), .z_in(pz[i]), .side_in(ps[i]),
			.vld_out(pv[i+1]), .x_out(px[i+1]), .y_out(py[i+1]), .z_out(pz[i+1]),
			.side_out(ps[i+1])
		);
	end

	// Multiply stage: scale times (angle plus offset), Q.26 products.
	logic signed [AW-1:0] ang_r, ang_c;
	logic vld_s1;
	logic [1:0] st_s1;
	logic signed [PW-1:0] pr_s1, pc_s1;

	assign ang_r = pz[N] + AW'(row_off_q);
	assign ang_c = ps[N].psi + AW'(col_off_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= ps[N].st;
			pr_s1 <= $signed({1'b0, row_sc_q}) * ang_r;
			pc_s1 <= $signed({1'b0, col_sc_q}) * ang_c;
		end
	end

	// Rounding half away from zero, range check and output register.
	function automatic logic signed [AW-1:0] round_q26(input logic signed [PW-1:0] p);
		logic [PW-1:0] m;
		logic [PW-1:0] r;
		m = p[PW-1] ? PW'(-p) : PW'(p);
		r = (m + (PW'(1) << 25)) >> 26;
		return p[PW-1] ? -AW'(r) : AW'(r);
	endfunction

	logic signed [AW-1:0] u, v;
	logic outside;
	logic vld_q;
	logic [11:0] row_q, col_q, mrow_q;
	logic [1:0] st_q;

	assign u = round_q26(pr_s1);
	assign v = round_q26(pc_s1);
	assign outside = u[AW-1] || u >= ROWS_S || v[AW-1] || v >= COLS_S;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (st_s1 != ST_OK || outside) begin
				st_q   <= (st_s1 != ST_OK) ? st_s1 : ST_OUT;
				row_q  <= '0;
				col_q  <= '0;
				mrow_q <= '0;
			end else begin
				st_q   <= ST_OK;
				row_q  <= u[11:0];
				col_q  <= v[11:0];
				mrow_q <= ROW_MAX - u[11:0];
			end
		end
	end

	assign out_valid  = vld_q;
	assign source_row = row_q;
	assign source_col = col_q;
	assign memory_row = mrow_q;
	assign status     = st_q;

	// A result that is not usable carries zero coordinates.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (source_row == 12'd0 && source_col == 12'd0
			&& memory_row == 12'd0))
		else $error("non-ok result carries coordinates");

	// A usable result lies inside the frame and its buffer row mirrors it.
	a_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (memory_row == ROW_MAX - source_row
			&& 13'(source_row) < 13'(IMG_ROWS) && 13'(source_col) < 13'(IMG_COLS)))
		else $error("usable result outside frame");

	// A held result keeps its status and source row while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(source_row)))
		else $error("stalled result changed");

endmodule
